@@ rtl/core/fconv_pkg.sv @@
// Shared types and constants for the full-convolution FIR block.
// Used by every module under rtl/core; no dependencies of its own.
package fconv_pkg;

	localparam int MAX_TAPS_DEF = 32;
	localparam int SAMPLE_W     = 16;
	localparam int IDX_W        = 5;
	localparam int TAPCNT_W     = 6;
	localparam int PROD_W       = 32;
	localparam int RES_W        = 37;
	localparam int S_TDATA_W    = 40;
	localparam int M_TDATA_W    = 40;
	localparam int QUEUE_DEPTH  = 4;

	typedef enum logic [1:0] {
		OP_COEF,
		OP_SAMPLE,
		OP_SAMPLE_END,
		OP_DROP
	} op_kind_t;

	typedef struct packed {
		op_kind_t            kind;
		logic [IDX_W-1:0]    idx;
		logic [SAMPLE_W-1:0] data;
	} op_t;

	typedef struct packed {
		logic                shift;
		logic                clear;
		logic                coef_wr;
		logic                tok;
		logic                last;
		logic [IDX_W-1:0]    idx;
		logic [SAMPLE_W-1:0] data;
	} step_t;

endpackage

@@ rtl/core/fconv_front.sv @@
// Input side: takes stream transfers and decodes them into queue operations.
// Depends on fconv_pkg; feeds fconv_fifo.
module fconv_front #(
	parameter int MAX_TAPS = fconv_pkg::MAX_TAPS_DEF
) (
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [fconv_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	input  logic                             s_axis_tuser,
	input  logic                             s_axis_tlast,
	input  logic                             q_full,
	output logic                             push,
	output fconv_pkg::op_t                   op
);

	logic [fconv_pkg::IDX_W-1:0]    idx;
	logic [fconv_pkg::SAMPLE_W-1:0] coef_value;
	logic [fconv_pkg::SAMPLE_W-1:0] sample;

	assign idx        = s_axis_tdata[fconv_pkg::IDX_W-1:0];
	assign coef_value = s_axis_tdata[fconv_pkg::IDX_W +: fconv_pkg::SAMPLE_W];
	assign sample     = s_axis_tdata[fconv_pkg::IDX_W + fconv_pkg::SAMPLE_W +: fconv_pkg::SAMPLE_W];

	always_comb begin
		op.idx = idx;
		if (s_axis_tuser) begin
			op.data = sample;
			op.kind = s_axis_tlast ? fconv_pkg::OP_SAMPLE_END : fconv_pkg::OP_SAMPLE;
		end else begin
			op.data = coef_value;
			op.kind = (32'(idx) < MAX_TAPS) ? fconv_pkg::OP_COEF : fconv_pkg::OP_DROP;
		end
	end

	// drop out-of-range coefficient writes at the door
	assign s_axis_tready = !q_full;
	assign push = s_axis_tvalid && !q_full && (op.kind != fconv_pkg::OP_DROP);

endmodule

@@ rtl/core/fconv_fifo.sv @@
// Short operation queue between the input decoder and the sequencer.
// Depends on fconv_pkg for the operation type and depth.
module fconv_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fconv_pkg::op_t push_op,
	output logic           full,
	input  logic           pop,
	output logic           vld,
	output fconv_pkg::op_t head
);

	localparam int DEPTH = fconv_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	fconv_pkg::op_t    mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign vld     = (cnt_q != '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_op;
	end

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count did not advance on push");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> (cnt_q == CNT_W'(DEPTH)) || (cnt_q == CNT_W'(DEPTH - 1)))
		else $error("queue count left range");

endmodule

@@ rtl/core/fconv_seq.sv @@
// Sequencer: pops queued operations, holds tap_count, and issues flush steps.
// Depends on fconv_pkg; drives fconv_mac with one step per advance.
module fconv_seq #(
	parameter int MAX_TAPS = fconv_pkg::MAX_TAPS_DEF,
	localparam int TAP_W   = $clog2(MAX_TAPS + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [fconv_pkg::TAPCNT_W-1:0]  cfg_wdata,
	input  logic                            q_vld,
	input  fconv_pkg::op_t                  q_op,
	output logic                            pop,
	input  logic                            adv,
	output fconv_pkg::step_t                step,
	output logic [TAP_W-1:0]                taps
);

	logic [fconv_pkg::TAPCNT_W-1:0] tap_count_q;
	logic [TAP_W-1:0]               flush_left_q;
	logic                           clr_pend_q;
	logic                           flushing;

	always_comb begin
		if (tap_count_q == '0)
			taps = TAP_W'(1);
		else if (32'(tap_count_q) > MAX_TAPS)
			taps = TAP_W'(MAX_TAPS);
		else
			taps = TAP_W'(tap_count_q);
	end

	assign flushing = (flush_left_q != '0);
	assign pop      = adv && !flushing && q_vld;

	always_comb begin
		step = '0;
		if (flushing) begin
			step.shift = 1'b1;
			step.tok   = 1'b1;
			step.last  = (flush_left_q == TAP_W'(1));
		end else if (q_vld) begin
			step.idx  = q_op.idx;
			step.data = q_op.data;
			case (q_op.kind)
				fconv_pkg::OP_COEF: begin
					step.coef_wr = 1'b1;
				end
				fconv_pkg::OP_SAMPLE: begin
					step.shift = 1'b1;
					step.clear = clr_pend_q;
					step.tok   = 1'b1;
				end
				fconv_pkg::OP_SAMPLE_END: begin
					step.shift = 1'b1;
					step.clear = clr_pend_q;
					step.tok   = 1'b1;
					step.last  = (taps == TAP_W'(1));
				end
				default: begin
					step = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q  <= fconv_pkg::TAPCNT_W'(1);
			flush_left_q <= '0;
			clr_pend_q   <= 1'b0;
		end else begin
			if (cfg_wen)
				tap_count_q <= cfg_wdata;
			if (adv) begin
				if (flushing) begin
					flush_left_q <= flush_left_q - 1'b1;
					if (flush_left_q == TAP_W'(1))
						clr_pend_q <= 1'b1;
				end else if (q_vld && step.shift) begin
					clr_pend_q <= 1'b0;
					if (q_op.kind == fconv_pkg::OP_SAMPLE_END) begin
						if (taps == TAP_W'(1))
							clr_pend_q <= 1'b1;
						else
							flush_left_q <= taps - 1'b1;
					end
				end
			end
		end
	end

	a_flush_blocks_pop: assert property (@(posedge clk) disable iff (!arst_n)
		flushing |-> !pop)
		else $error("queue popped during flush");
	a_flush_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && flush_left_q == TAP_W'(1)) |=> (clr_pend_q && !flushing))
		else $error("history clear not armed after flush");

endmodule

@@ rtl/core/fconv_mac.sv @@
// Datapath: history line, coefficient store, parallel tap products and
// registered adder tree. Depends on fconv_pkg; stepped by fconv_seq.
module fconv_mac #(
	parameter int MAX_TAPS = fconv_pkg::MAX_TAPS_DEF,
	localparam int TAP_W   = $clog2(MAX_TAPS + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fconv_pkg::step_t                step,
	input  logic [TAP_W-1:0]                taps,
	output logic                            adv,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [fconv_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tlast
);

	localparam int LEVELS = $clog2(MAX_TAPS);
	localparam int LEAVES = 1 << LEVELS;
	localparam int D      = LEVELS + 1;
	localparam int RES_W  = fconv_pkg::RES_W;
	localparam int PROD_W = fconv_pkg::PROD_W;

	logic signed [fconv_pkg::SAMPLE_W-1:0] hist_q [MAX_TAPS];
	logic signed [fconv_pkg::SAMPLE_W-1:0] coef_q [MAX_TAPS];
	logic                                  en [MAX_TAPS];
	logic signed [PROD_W-1:0]              prod_s1 [MAX_TAPS];
	logic signed [RES_W-1:0]               node_q [LEAVES-1];
	logic signed [RES_W-1:0]               tree_in [2*LEAVES-1];
	logic [D:0]                            tok_vld_q;
	logic [D:0]                            tok_last_q;

	assign adv = !tok_vld_q[D] || m_axis_tready;

	always_comb begin
		for (int i = 0; i < MAX_TAPS; i++)
			en[i] = (taps > TAP_W'(i));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				hist_q[i] <= '0;
				coef_q[i] <= '0;
			end
			tok_vld_q <= '0;
		end else if (adv) begin
			if (step.shift) begin
				hist_q[0] <= step.data;
				for (int i = 1; i < MAX_TAPS; i++)
					hist_q[i] <= step.clear ? '0 : hist_q[i-1];
			end
			if (step.coef_wr) begin
				for (int i = 0; i < MAX_TAPS; i++)
					if (32'(step.idx) == i)
						coef_q[i] <= step.data;
			end
			tok_vld_q <= {tok_vld_q[D-1:0], step.tok};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_last_q <= {tok_last_q[D-1:0], step.last};
			for (int i = 0; i < MAX_TAPS; i++) begin
				if (en[i])
					prod_s1[i] <= hist_q[i] * coef_q[i];
				else
					prod_s1[i] <= '0;
			end
			for (int k = 0; k < LEAVES - 1; k++)
				node_q[k] <= tree_in[2*k+1] + tree_in[2*k+2];
		end
	end

	for (genvar k = 0; k < 2*LEAVES - 1; k++) begin : g_tree_in
		if (k < LEAVES - 1) begin : g_node
			assign tree_in[k] = node_q[k];
		end else if (k - (LEAVES - 1) < MAX_TAPS) begin : g_leaf
			assign tree_in[k] = {{(RES_W-PROD_W){prod_s1[k-(LEAVES-1)][PROD_W-1]}},
				prod_s1[k-(LEAVES-1)]};
		end else begin : g_pad
			assign tree_in[k] = '0;
		end
	end

	assign m_axis_tvalid = tok_vld_q[D];
	assign m_axis_tlast  = tok_last_q[D];
	assign m_axis_tdata  = {{(fconv_pkg::M_TDATA_W-RES_W){1'b0}}, node_q[0]};

	a_hold_history: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(hist_q[0]) && $stable(tok_vld_q))
		else $error("pipeline moved while stalled");
	a_stall_only_on_output: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> tok_vld_q[D])
		else $error("stall without a pending result");

endmodule

@@ rtl/core/fir_full_convolution.sv @@
// Full linear convolution FIR: stream in coefficients and samples, stream out sums.
// Depends on fconv_pkg, fconv_front, fconv_fifo, fconv_seq and fconv_mac.
//
// Input channel s_axis: tuser = 0 writes coefficient coef_value at tap coef_index,
// tuser = 1 feeds one sample; tlast on a sample marks the end of a block.
// Coefficient writes to taps at or beyond MAX_TAPS are accepted and dropped.
// Output channel m_axis: one 37-bit signed Q22.15 sum per sample, plus
// tap_count-1 flush sums after a block end; tlast marks the final sum of a block.
// cfg_wen/cfg_wdata set tap_count (0 acts as 1, above MAX_TAPS acts as MAX_TAPS);
// write it only while the block is idle.
// Throughput: one item per cycle while m_axis is not stalled; a block end adds
// tap_count-1 flush steps, one sum each, issued by the sequencer while the queue waits.
// From the queue, each item passes the history line, the tap product register
// and the registered adder tree before its result reaches m_axis.
// A four-entry queue sits between input and datapath, so s_axis keeps taking
// items while a result waits; a stalled m_axis freezes the datapath and the
// queue fills, then s_axis_tready drops.
// Reset clears history and coefficients to zero and sets tap_count to 1.
module fir_full_convolution #(
	parameter int MAX_TAPS = fconv_pkg::MAX_TAPS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [fconv_pkg::TAPCNT_W-1:0]  cfg_wdata,      // tap_count
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [fconv_pkg::S_TDATA_W-1:0] s_axis_tdata,   // coef_index, coef_value, sample
	input  logic                            s_axis_tuser,   // func
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [fconv_pkg::M_TDATA_W-1:0] m_axis_tdata,   // result
	output logic                            m_axis_tlast
);

	localparam int TAP_W = $clog2(MAX_TAPS + 1);

	fconv_pkg::op_t   push_op;
	fconv_pkg::op_t   head_op;
	fconv_pkg::step_t step;
	logic             push;
	logic             q_full;
	logic             q_vld;
	logic             pop;
	logic             adv;
	logic [TAP_W-1:0] taps;

	fconv_front #(.MAX_TAPS(MAX_TAPS)) u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.push          (push),
		.op            (push_op)
	);

	fconv_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.vld     (q_vld),
		.head    (head_op)
	);

	fconv_seq #(.MAX_TAPS(MAX_TAPS)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.q_vld     (q_vld),
		.q_op      (head_op),
		.pop       (pop),
		.adv       (adv),
		.step      (step),
		.taps      (taps)
	);

	fconv_mac #(.MAX_TAPS(MAX_TAPS)) u_mac (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.taps          (taps),
		.adv           (adv),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
